// ===== rtl/core/rotary_stage_move_sequencer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rotary stage move sequencer.
// Both macros expect signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ROTARY_STAGE_MOVE_SEQUENCER_UNIT_ASSERT_SVH
`define ROTARY_STAGE_MOVE_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, checked only while reset is released.
`define RSMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsms assertion failed");

// Next-cycle implication, checked only while reset is released.
`define RSMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsms assertion failed");

`endif

// ===== rtl/core/rsms_pkg.sv =====
// ----------------------------------------------------------------------------
// rsms_pkg
// Shared types and constants of the rotary stage move sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rsms_pkg;

    // Angle handling. The target wrap in the front reduces values that lie
    // within two turns of the range, which covers the 13-bit input range.
    localparam int STEPS_PER_TURN = 2880;
    localparam int HALF_TURN      = STEPS_PER_TURN / 2;
    localparam int POS_W          = 12;

    // Command codes.
    localparam logic [2:0] CMD_GOTO      = 3'd0;
    localparam logic [2:0] CMD_MOVE_REL  = 3'd1;
    localparam logic [2:0] CMD_RESET     = 3'd2;
    localparam logic [2:0] CMD_SET_ZERO  = 3'd3;
    localparam logic [2:0] CMD_SET_BL    = 3'd4;

    // Last motor direction.
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    // Controller bytes and port 1 control lines.
    localparam logic [7:0] BYTE_CMD_RESET  = 8'h19;
    localparam logic [7:0] BYTE_CMD_COUNT  = 8'h1A;
    localparam logic [7:0] BYTE_CMD_STORE  = 8'h1B;
    localparam logic [7:0] BYTE_CMD_DOWN   = 8'h1C;
    localparam logic [7:0] BYTE_CMD_UP     = 8'h1D;
    localparam logic [7:0] BYTE_STORE_DATA = 8'h07;
    localparam logic [7:0] BYTE_ALL_ONES   = 8'hFF;
    localparam logic [7:0] NIBBLE_ONES     = 8'h0F;
    localparam logic [7:0] LINE_LATCH      = 8'h10;
    localparam logic [7:0] LINE_DATA       = 8'h20;
    localparam logic [7:0] LINE_STROBE     = 8'h80;

    localparam logic [7:0] BACKLASH_RESET  = 8'd96;

    // Beats per sequence.
    localparam int MOVE_BEATS  = 23;
    localparam int RESET_BEATS = 9;
    localparam int STEP_W      = $clog2(MOVE_BEATS);

    // Command queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // One planned command: optional double reset sequence, then up to two
    // moves. When there are two moves the first goes down, the second up.
    typedef struct packed {
        logic             rst;
        logic [1:0]       nmov;
        logic             m0_up;
        logic [POS_W-1:0] m0_cnt;
        logic [POS_W-1:0] m1_cnt;
        logic [POS_W-1:0] position;
        logic             bl_on;
    } rsms_plan_t;

    typedef struct packed {
        logic             kind;
        logic             port;
        logic [7:0]       value;
        logic             hold;
        logic [POS_W-1:0] wait_steps;
        logic [POS_W-1:0] position;
        logic             backlash_on;
        logic             last;
    } rsms_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rsms_if.sv =====
// ----------------------------------------------------------------------------
// rsms channel interfaces
// Command, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsms_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic signed [12:0] position_value;
    logic               enable;

    modport source (output valid, cmd, position_value, enable, input ready);
    modport sink   (input valid, cmd, position_value, enable, output ready);
endinterface

interface rsms_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        port;
    logic [7:0]  value;
    logic        hold;
    logic [11:0] wait_steps;
    logic [11:0] position;
    logic        backlash_on;
    logic        last;

    modport source (output valid, kind, port, value, hold, wait_steps, position,
                    backlash_on, last, input ready);
    modport sink   (input valid, kind, port, value, hold, wait_steps, position,
                    backlash_on, last, output ready);
endinterface

interface rsms_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rotary_stage_move_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// rotary_stage_move_sequencer_unit
// Plans rotary stage moves and emits the motor controller port writes.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes one command per beat (go to, move relative, reset,
// set zero, backlash correction on/off). Each command yields a run of beats
// on the rsp channel, one per port write, with last set on the final beat.
// A command that moves nothing yields a single status beat with kind low.
// Beat counts: status 1, single move 23, move with correction 46, correction
// switch-on 46, reset 18 or 64 with correction enabled.
// The cfg channel loads the backlash overshoot; it is always ready and must
// only be written while no command is in flight.
// An accepted command passes to its first result beat through the planning
// register, the two-entry command queue and the output register.
// The back end emits one beat per cycle while rsp is not stalled, and a
// command holds it until its last beat is out; the front accepts one command
// per cycle as long as the queue has room.
// Reset clears position, correction and direction state and the port 1
// shadow, and loads the overshoot with 96 steps. When rsp is stalled the
// output register holds its beat and the queue fills before req drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_stage_move_sequencer_unit import rsms_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    rsms_req_if.sink  req,
    rsms_rsp_if.source rsp,
    rsms_cfg_if.sink  cfg
);

    logic [7:0] backlash_reg, backlash_next;

    rsms_plan_t front_plan, queue_plan;
    logic       front_valid, front_ready;
    logic       queue_valid, queue_ready;

    // The overshoot register is written directly from the configuration
    // channel, which never stalls.
    assign cfg.ready     = 1'b1;
    assign backlash_next = (cfg.valid) ? cfg.data : backlash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlash_reg <= BACKLASH_RESET;
        end
        else
        begin
            backlash_reg <= backlash_next;
        end
    end

    // Front: accepts commands, keeps the position and correction state, and
    // reduces each command to a plan of reset sequences and moves.
    rsms_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .backlash_steps (backlash_reg),
        .plan           (front_plan),
        .plan_valid     (front_valid),
        .plan_ready     (front_ready)
    );

    // Queue: lets the front keep planning while the back works off a long
    // sequence.
    rsms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_plan   (front_plan),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_plan  (queue_plan),
        .out_valid (queue_valid),
        .out_ready (queue_ready)
    );

    // Back: walks the plan and emits one port write per beat.
    rsms_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan       (queue_plan),
        .plan_valid (queue_valid),
        .plan_ready (queue_ready),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rsms_front.sv =====
// ----------------------------------------------------------------------------
// rsms_front
// Accepts commands, tracks position and correction state, and plans moves.
// ----------------------------------------------------------------------------
`default_nettype none

module rsms_front import rsms_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    rsms_req_if.sink        req,
    input  wire logic [7:0] backlash_steps,
    output rsms_plan_t      plan,
    output logic            plan_valid,
    input  wire logic       plan_ready
);

    localparam logic signed [14:0] TURN15 = 15'(STEPS_PER_TURN);
    localparam logic signed [13:0] TURN14 = 14'(STEPS_PER_TURN);
    localparam logic signed [13:0] HALF14 = 14'(HALF_TURN);

    // Architectural state; position and correction update on accept, direction as a plan leaves.
    logic [POS_W-1:0] cur_pos_reg, cur_pos_next;
    logic             bl_en_reg, bl_en_next;
    logic [1:0]       last_dir_reg, last_dir_next;

    // Planning stage.
    logic             b_valid_reg, b_valid_next;
    logic [2:0]       b_cmd_reg, b_cmd_next;
    logic [POS_W-1:0] b_target_reg, b_target_next;
    logic [POS_W-1:0] b_old_pos_reg, b_old_pos_next;
    logic             b_old_bl_reg, b_old_bl_next;
    logic             b_en_reg, b_en_next;

    logic               accept;
    logic               b_adv;
    logic signed [14:0] sum;
    logic signed [14:0] c_p1, c_p2, c_m1, c_m2, wrapped;
    logic [POS_W-1:0]   target;

    logic signed [13:0] diff, dn, dn_neg, pos_bl, lim, bl_ext, far_cnt;
    rsms_plan_t         plan_w;

    assign b_adv     = b_valid_reg && plan_ready;
    assign req.ready = !b_valid_reg || plan_ready;
    assign accept    = req.valid && req.ready;

    // Wrap of the requested target into one turn. All candidates are formed
    // in parallel and the one that lands in range is picked.
    always_comb
    begin
        sum = {{2{req.position_value[12]}}, req.position_value};
        if (req.cmd == CMD_MOVE_REL)
        begin
            sum = sum + {3'b000, cur_pos_reg};
        end
        c_p1 = sum + TURN15;
        c_p2 = sum + (TURN15 <<< 1);
        c_m1 = sum - TURN15;
        c_m2 = sum - (TURN15 <<< 1);
        if (sum < 0)
        begin
            wrapped = (c_p1 >= 0) ? c_p1 : c_p2;
        end
        else if (sum < TURN15)
        begin
            wrapped = sum;
        end
        else
        begin
            wrapped = (c_m1 < TURN15) ? c_m1 : c_m2;
        end
        target = wrapped[POS_W-1:0];
    end

    always_comb
    begin
        cur_pos_next   = cur_pos_reg;
        bl_en_next     = bl_en_reg;
        b_valid_next   = b_valid_reg;
        b_cmd_next     = b_cmd_reg;
        b_target_next  = b_target_reg;
        b_old_pos_next = b_old_pos_reg;
        b_old_bl_next  = b_old_bl_reg;
        b_en_next      = b_en_reg;
        if (b_adv)
        begin
            b_valid_next = 1'b0;
        end
        if (accept)
        begin
            b_valid_next   = 1'b1;
            b_cmd_next     = req.cmd;
            b_target_next  = target;
            b_old_pos_next = cur_pos_reg;
            b_old_bl_next  = bl_en_reg;
            b_en_next      = req.enable;
            case (req.cmd)
                CMD_GOTO, CMD_MOVE_REL: cur_pos_next = target;
                CMD_RESET, CMD_SET_ZERO: cur_pos_next = '0;
                CMD_SET_BL: bl_en_next = req.enable;
                default: ;
            endcase
        end
    end

    // Move planning for the command held in the planning stage.
    always_comb
    begin
        diff    = {2'b00, b_target_reg} - {2'b00, b_old_pos_reg};
        bl_ext  = {6'd0, backlash_steps};
        dn      = diff;
        if (diff < -HALF14)
        begin
            dn = diff + TURN14;
        end
        else if (diff > HALF14)
        begin
            dn = diff - TURN14;
        end
        dn_neg  = -dn;
        pos_bl  = (diff < 0) ? diff + TURN14 : diff;
        lim     = HALF14 + (bl_ext <<< 1);
        far_cnt = TURN14 - pos_bl + bl_ext;

        plan_w          = '0;
        plan_w.bl_on    = bl_en_reg;
        plan_w.position = cur_pos_reg;
        case (b_cmd_reg)
            CMD_GOTO, CMD_MOVE_REL:
            begin
                if (diff != 0)
                begin
                    if (!b_old_bl_reg)
                    begin
                        plan_w.nmov   = 2'd1;
                        plan_w.m0_up  = (dn > 0);
                        plan_w.m0_cnt = (dn > 0) ? dn[POS_W-1:0] : dn_neg[POS_W-1:0];
                    end
                    else if (pos_bl <= lim)
                    begin
                        plan_w.nmov   = 2'd1;
                        plan_w.m0_up  = 1'b1;
                        plan_w.m0_cnt = pos_bl[POS_W-1:0];
                    end
                    else
                    begin
                        // Go down past the target, then take up the backlash.
                        plan_w.nmov   = 2'd2;
                        plan_w.m0_cnt = far_cnt[POS_W-1:0];
                        plan_w.m1_cnt = bl_ext[POS_W-1:0];
                    end
                end
            end
            CMD_RESET:
            begin
                plan_w.rst = 1'b1;
                if (b_old_bl_reg)
                begin
                    plan_w.nmov   = 2'd2;
                    plan_w.m0_cnt = bl_ext[POS_W-1:0];
                    plan_w.m1_cnt = bl_ext[POS_W-1:0];
                end
            end
            CMD_SET_BL:
            begin
                if (b_en_reg && !b_old_bl_reg && last_dir_reg != DIR_UP)
                begin
                    plan_w.nmov   = 2'd2;
                    plan_w.m0_cnt = bl_ext[POS_W-1:0];
                    plan_w.m1_cnt = bl_ext[POS_W-1:0];
                end
            end
            default: ;
        endcase

        // The position and setting reported are those after this command,
        // which the state registers already hold.
        plan_w.position = b_target_reg;
        if (b_cmd_reg != CMD_GOTO && b_cmd_reg != CMD_MOVE_REL)
        begin
            plan_w.position = (b_cmd_reg == CMD_RESET || b_cmd_reg == CMD_SET_ZERO)
                              ? '0 : b_old_pos_reg;
        end
        plan_w.bl_on = (b_cmd_reg == CMD_SET_BL) ? b_en_reg : b_old_bl_reg;

        last_dir_next = last_dir_reg;
        if (b_adv)
        begin
            if (plan_w.nmov == 2'd2)
            begin
                last_dir_next = DIR_UP;
            end
            else if (plan_w.nmov == 2'd1)
            begin
                last_dir_next = plan_w.m0_up ? DIR_UP : DIR_DOWN;
            end
        end
    end

    assign plan       = plan_w;
    assign plan_valid = b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg  <= '0;
            bl_en_reg    <= 1'b0;
            last_dir_reg <= DIR_NONE;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_pos_reg  <= cur_pos_next;
            bl_en_reg    <= bl_en_next;
            last_dir_reg <= last_dir_next;
            b_valid_reg  <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_cmd_reg     <= b_cmd_next;
        b_target_reg  <= b_target_next;
        b_old_pos_reg <= b_old_pos_next;
        b_old_bl_reg  <= b_old_bl_next;
        b_en_reg      <= b_en_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/rsms_queue.sv =====
// ----------------------------------------------------------------------------
// rsms_queue
// Short FIFO of planned commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rsms_queue import rsms_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire rsms_plan_t in_plan,
    input  wire logic       in_valid,
    output logic            in_ready,
    output rsms_plan_t      out_plan,
    output logic            out_valid,
    input  wire logic       out_ready
);

    rsms_plan_t        entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push, pop;

    assign in_ready  = (cnt_reg != QCNT_W'(Q_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_plan  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_plan;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rsms_back.sv =====
// ----------------------------------------------------------------------------
// rsms_back
// Turns planned commands into port-write beats, one beat per cycle while rsp is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module rsms_back import rsms_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire rsms_plan_t plan,
    input  wire logic       plan_valid,
    output logic            plan_ready,
    rsms_rsp_if.source      rsp
);

    localparam logic [2:0] SEG_RST_A = 3'd0;
    localparam logic [2:0] SEG_RST_B = 3'd1;
    localparam logic [2:0] SEG_MV0   = 3'd2;
    localparam logic [2:0] SEG_MV1   = 3'd3;
    localparam logic [2:0] SEG_STAT  = 3'd4;

    logic [2:0]        seg_reg, seg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              started_reg, started_next;
    logic [7:0]        shadow_reg, shadow_next;
    logic              out_valid_reg, out_valid_next;
    rsms_beat_t        out_beat_reg, out_beat_next;

    logic [2:0]        seg, first_seg, nxt_seg;
    logic [STEP_W-1:0] step, last_step;
    logic              has_next, at_end, final_beat, fire, out_free;
    logic              mv_up;
    logic [POS_W-1:0]  mv_cnt, inv;
    logic              set_shadow;
    rsms_beat_t        beat;

    assign out_free = !out_valid_reg || rsp.ready;
    assign fire     = plan_valid && out_free;

    always_comb
    begin
        if (plan.rst)
        begin
            first_seg = SEG_RST_A;
        end
        else if (plan.nmov != 2'd0)
        begin
            first_seg = SEG_MV0;
        end
        else
        begin
            first_seg = SEG_STAT;
        end
        seg  = started_reg ? seg_reg : first_seg;
        step = started_reg ? step_reg : '0;

        case (seg)
            SEG_RST_A, SEG_RST_B: last_step = STEP_W'(RESET_BEATS - 1);
            SEG_MV0, SEG_MV1:     last_step = STEP_W'(MOVE_BEATS - 1);
            default:              last_step = '0;
        endcase

        has_next = 1'b0;
        nxt_seg  = SEG_STAT;
        case (seg)
            SEG_RST_A:
            begin
                has_next = 1'b1;
                nxt_seg  = SEG_RST_B;
            end
            SEG_RST_B:
            begin
                has_next = (plan.nmov != 2'd0);
                nxt_seg  = SEG_MV0;
            end
            SEG_MV0:
            begin
                has_next = (plan.nmov == 2'd2);
                nxt_seg  = SEG_MV1;
            end
            default: ;
        endcase

        at_end     = (step == last_step);
        final_beat = at_end && !has_next;
        plan_ready = fire && final_beat;
    end

    // Beat table. Pulses set a control line on top of the port 1 shadow and
    // then drop it again; a few beats load the shadow itself.
    always_comb
    begin
        mv_up  = (seg == SEG_MV1) ? 1'b1 : plan.m0_up;
        mv_cnt = (seg == SEG_MV1) ? plan.m1_cnt : plan.m0_cnt;
        inv    = ~mv_cnt;

        beat             = '0;
        beat.kind        = 1'b1;
        beat.port        = 1'b1;
        beat.value       = shadow_reg;
        beat.position    = plan.position;
        beat.backlash_on = plan.bl_on;
        beat.last        = final_beat;
        set_shadow       = 1'b0;

        if (seg == SEG_STAT)
        begin
            beat.kind  = 1'b0;
            beat.port  = 1'b0;
            beat.value = '0;
        end
        else if (seg == SEG_RST_A || seg == SEG_RST_B)
        begin
            case (step)
                STEP_W'(0):
                begin
                    beat.port  = 1'b0;
                    beat.value = BYTE_CMD_RESET;
                end
                STEP_W'(1):
                begin
                    beat.value = shadow_reg | LINE_LATCH;
                    beat.hold  = 1'b1;
                end
                STEP_W'(3):
                begin
                    beat.port  = 1'b0;
                    beat.value = BYTE_ALL_ONES;
                end
                STEP_W'(4):
                begin
                    beat.value = NIBBLE_ONES;
                    set_shadow = 1'b1;
                end
                STEP_W'(5):
                begin
                    beat.value = shadow_reg | LINE_DATA;
                    beat.hold  = 1'b1;
                end
                STEP_W'(7):
                begin
                    beat.value = shadow_reg | LINE_STROBE;
                    beat.hold  = 1'b1;
                end
                STEP_W'(8): beat.wait_steps = POS_W'(STEPS_PER_TURN);
                default: ;
            endcase
        end
        else
        begin
            case (step)
                STEP_W'(0):
                begin
                    beat.port  = 1'b0;
                    beat.value = BYTE_CMD_COUNT;
                end
                STEP_W'(3):
                begin
                    beat.port  = 1'b0;
                    beat.value = inv[7:0];
                end
                STEP_W'(4):
                begin
                    beat.value = {4'b0000, inv[POS_W-1:8]};
                    set_shadow = 1'b1;
                end
                STEP_W'(9):
                begin
                    beat.port  = 1'b0;
                    beat.value = BYTE_CMD_STORE;
                end
                STEP_W'(12):
                begin
                    beat.port  = 1'b0;
                    beat.value = BYTE_STORE_DATA;
                end
                STEP_W'(13):
                begin
                    beat.value = '0;
                    set_shadow = 1'b1;
                end
                STEP_W'(18):
                begin
                    beat.port  = 1'b0;
                    beat.value = mv_up ? BYTE_CMD_UP : BYTE_CMD_DOWN;
                end
                STEP_W'(1), STEP_W'(10), STEP_W'(19):
                begin
                    beat.value = shadow_reg | LINE_LATCH;
                    beat.hold  = 1'b1;
                end
                STEP_W'(5), STEP_W'(14):
                begin
                    beat.value = shadow_reg | LINE_DATA;
                    beat.hold  = 1'b1;
                end
                STEP_W'(7), STEP_W'(16), STEP_W'(21):
                begin
                    beat.value = shadow_reg | LINE_STROBE;
                    beat.hold  = 1'b1;
                end
                STEP_W'(22): beat.wait_steps = mv_cnt;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        seg_next       = seg_reg;
        step_next      = step_reg;
        started_next   = started_reg;
        shadow_next    = shadow_reg;
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        if (fire)
        begin
            if (set_shadow)
            begin
                shadow_next = beat.value;
            end
            if (!at_end)
            begin
                seg_next     = seg;
                step_next    = step + 1'b1;
                started_next = 1'b1;
            end
            else if (has_next)
            begin
                seg_next     = nxt_seg;
                step_next    = '0;
                started_next = 1'b1;
            end
            else
            begin
                started_next = 1'b0;
            end
        end
        if (out_free)
        begin
            out_valid_next = fire;
            out_beat_next  = beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= SEG_STAT;
            step_reg      <= '0;
            started_reg   <= 1'b0;
            shadow_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg       <= seg_next;
            step_reg      <= step_next;
            started_reg   <= started_next;
            shadow_reg    <= shadow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_beat_reg.kind;
    assign rsp.port        = out_beat_reg.port;
    assign rsp.value       = out_beat_reg.value;
    assign rsp.hold        = out_beat_reg.hold;
    assign rsp.wait_steps  = out_beat_reg.wait_steps;
    assign rsp.position    = out_beat_reg.position;
    assign rsp.backlash_on = out_beat_reg.backlash_on;
    assign rsp.last        = out_beat_reg.last;

endmodule

`default_nettype wire

// ===== rtl/core/rsms_checker.sv =====
// ----------------------------------------------------------------------------
// rsms_checker
// Port-level checks on the result beats of the move sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotary_stage_move_sequencer_unit_assert.svh"

module rsms_checker import rsms_pkg::*; (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        rsp_kind,
    input wire logic        rsp_port,
    input wire logic [7:0]  rsp_value,
    input wire logic        rsp_hold,
    input wire logic [11:0] rsp_wait_steps,
    input wire logic [11:0] rsp_position,
    input wire logic        rsp_last
);

    // A status beat stands alone and carries no write.
    `RSMS_ASSERT_IMP(a_status_alone, rsp_valid && !rsp_kind,
        rsp_last && !rsp_port && rsp_value == 8'd0 && !rsp_hold && rsp_wait_steps == 12'd0)

    // A held pulse is a port 1 write that never ends a command.
    `RSMS_ASSERT_IMP(a_hold_inside, rsp_valid && rsp_hold,
        rsp_kind && rsp_port && !rsp_last && rsp_wait_steps == 12'd0)

    // The reported position always lies within one turn.
    `RSMS_ASSERT_IMP(a_pos_range, rsp_valid, rsp_position < 12'(STEPS_PER_TURN))

    // The beat after a taken pulse is the release write on port 1.
    `RSMS_ASSERT_NXT(a_pulse_release, rsp_valid && rsp_ready && rsp_hold,
        rsp_valid && rsp_port && !rsp_hold)

endmodule

bind rotary_stage_move_sequencer_unit rsms_checker u_rsms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_port       (rsp.port),
    .rsp_value      (rsp.value),
    .rsp_hold       (rsp.hold),
    .rsp_wait_steps (rsp.wait_steps),
    .rsp_position   (rsp.position),
    .rsp_last       (rsp.last)
);

`default_nettype wire
